### rtl/cts_pkg.sv
// Shared types, constants and the arctangent table for the spherical converter.
`default_nettype none

package cts_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int ANGLE_BITS_DEF    = 18;
  localparam int CORDIC_STAGES_DEF = 20;

  // Internal datapath: 64-bit words, angles kept with pi = 2^31.
  localparam int WORD_W   = 64;
  localparam int ANG_W    = 34;
  localparam int SHIFT_W  = 6;
  localparam int NORM_MSB = 57;

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  localparam ang_t PI_ANG      = 34'sh080000000;
  localparam ang_t HALF_PI_ANG = 34'sh040000000;

  // Per-request information that travels alongside the rotation data.
  typedef struct packed {
    logic                axis;
    logic                xzero;
    logic                yzero;
    logic                zzero;
    logic                xneg;
    logic                yneg;
    logic                zneg;
    logic [SHIFT_W-1:0]  n;
    word_t               z;
    word_t               zs;
    ang_t                phi;
    ang_t                theta;
  } side_t;

  // Rotation angle of CORDIC step idx, atan(2^-idx) with pi = 2^31.
  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/cts_if.sv
// Valid/ready channel interfaces for points in and spherical results out.
`default_nettype none

interface cts_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic signed [COORD_BITS-1:0] z_coord;

  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface cts_out_if #(parameter int COORD_BITS = 24, parameter int ANGLE_BITS = 18);
  logic                         valid;
  logic                         ready;
  logic [COORD_BITS-1:0]        radius;
  logic [ANGLE_BITS-1:0]        polar_angle;
  logic signed [ANGLE_BITS:0]   azimuth_angle;

  modport source (output valid, radius, polar_angle, azimuth_angle, input ready);
  modport sink   (input valid, radius, polar_angle, azimuth_angle, output ready);
endinterface

`default_nettype wire

### rtl/cts_cell.sv
// One vectoring CORDIC step with its pipeline register.
`default_nettype none

module cts_cell import cts_pkg::*; #(
  parameter int STG = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  side_t side_i,
  input  word_t a_i,
  input  word_t b_i,
  input  ang_t  ang_i,
  output logic  vld_o,
  output side_t side_o,
  output word_t a_o,
  output word_t b_o,
  output ang_t  ang_o
);

  localparam ang_t ATN = ang_t'(atan_entry(STG));

  word_t da, db, a_nxt, b_nxt;
  ang_t  ang_nxt;
  logic  vld_r;
  side_t side_r;
  word_t a_r, b_r;
  ang_t  ang_r;

  // Rotate toward the positive a axis, driving b to zero.
  always_comb begin
    da = b_i >>> STG;
    db = a_i >>> STG;
    if (!b_i[WORD_W-1]) begin
      a_nxt   = a_i + da;
      b_nxt   = b_i - db;
      ang_nxt = ang_i + ATN;
    end else begin
      a_nxt   = a_i - da;
      b_nxt   = b_i + db;
      ang_nxt = ang_i - ATN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      ang_r  <= ang_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign ang_o  = ang_r;

endmodule

`default_nettype wire

### rtl/cts_gain.sv
// Two-stage removal of the CORDIC gain by the constant 1/K.
`default_nettype none

module cts_gain import cts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  side_t side_i,
  input  word_t val_i,
  output logic  vld_o,
  output side_t side_o,
  output word_t val_o
);

  logic        vld1_r, vld2_r;
  side_t       side1_r, side2_r;
  logic [63:0] phi_r, plo_r;
  word_t       val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  // Partial products of the upper and lower halves, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_i;
      phi_r   <= val_i[63:32] * INV_GAIN;
      plo_r   <= val_i[31:0] * INV_GAIN;
      side2_r <= side1_r;
      val_r   <= word_t'(phi_r + {32'd0, plo_r[63:32]});
    end
  end

  assign vld_o  = vld2_r;
  assign side_o = side2_r;
  assign val_o  = val_r;

endmodule

`default_nettype wire

### rtl/cartesian_to_spherical_point_unit.sv
// Top level: pipelined cartesian to spherical conversion with two CORDIC chains.
`default_nettype none

// Converts a point (x, y, z) into radius, polar angle from +z and azimuth from +x,
// with angles scaled so that 2^(ANGLE_BITS-1) means pi. The block is a single
// pipeline that takes one request per clock while the output is not stalled; it is
// made of the two chains of CORDIC cells, the three normalization stages,
// the fold stage between the chains, the two two-stage gain multipliers and the
// output register. A stalled output holds the whole pipeline, and the input is
// ready whenever the output register is empty or being read.

module cartesian_to_spherical_point_unit import cts_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cts_in_if.sink     in_ch,
  cts_out_if.source  out_ch
);

  localparam int   CB       = COORD_BITS;
  localparam int   AB       = ANGLE_BITS;
  localparam int   CS       = CORDIC_STAGES;
  localparam int   SH       = 32 - AB;
  localparam ang_t HALF_ANG = (SH > 0) ? (ang_t'(1) << (SH - 1)) : ang_t'(0);
  localparam ang_t LIM_ANG  = ang_t'(1) << (AB - 1);
  localparam word_t RMAX    = (word_t'(1) << CB) - word_t'(1);

  function automatic ang_t clamp_ang(input ang_t v, input ang_t lo, input ang_t hi);
    ang_t r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic ang_t round_ang(input ang_t v);
    ang_t t;
    t = (v + HALF_ANG) >>> SH;
    return clamp_ang(t, -LIM_ANG, LIM_ANG);
  endfunction

  logic en;
  logic out_v_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: magnitudes and special-case flags.
  logic signed [CB-1:0] xi, yi, zi;
  logic [CB-1:0]        xa, ya, za;
  side_t                s1_nxt;
  logic                 v1_r;
  word_t                x1_r, y1_r;
  logic [CB-1:0]        mxy1_r, mz1_r;
  side_t                s1_r;

  always_comb begin
    xi = in_ch.x_coord;
    yi = in_ch.y_coord;
    zi = in_ch.z_coord;
    xa = xi[CB-1] ? CB'(-xi) : CB'(xi);
    ya = yi[CB-1] ? CB'(-yi) : CB'(yi);
    za = zi[CB-1] ? CB'(-zi) : CB'(zi);
    s1_nxt       = '0;
    s1_nxt.xzero = (xi == '0);
    s1_nxt.yzero = (yi == '0);
    s1_nxt.zzero = (zi == '0);
    s1_nxt.axis  = (xi == '0) && (yi == '0);
    s1_nxt.xneg  = xi[CB-1];
    s1_nxt.yneg  = yi[CB-1];
    s1_nxt.zneg  = zi[CB-1];
    s1_nxt.z     = word_t'(zi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= word_t'(xi);
      y1_r   <= word_t'(yi);
      mxy1_r <= (xa > ya) ? xa : ya;
      mz1_r  <= za;
      s1_r   <= s1_nxt;
    end
  end

  // Stage 2: largest magnitude and the common normalizing shift.
  logic [CB-1:0]      m2;
  logic [SHIFT_W-1:0] msb2;
  side_t              s2_nxt;
  logic               v2_r;
  word_t              x2_r, y2_r;
  side_t              s2_r;

  always_comb begin
    m2   = (mxy1_r > mz1_r) ? mxy1_r : mz1_r;
    msb2 = '0;
    for (int i = 0; i < CB; i++) begin
      if (m2[i]) msb2 = SHIFT_W'(i);
    end
    s2_nxt   = s1_r;
    s2_nxt.n = SHIFT_W'(NORM_MSB) - msb2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= x1_r;
      y2_r <= y1_r;
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: normalize and fold the left half plane onto the right.
  word_t xs3, ys3;
  side_t s3_nxt;
  logic  v3_r;
  word_t a3_r, b3_r;
  ang_t  g3_r;
  side_t s3_r;

  always_comb begin
    xs3       = x2_r <<< s2_r.n;
    ys3       = y2_r <<< s2_r.n;
    s3_nxt    = s2_r;
    s3_nxt.zs = s2_r.z <<< s2_r.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      if (s2_r.xneg) begin
        a3_r <= -xs3;
        b3_r <= -ys3;
        g3_r <= s2_r.yneg ? -PI_ANG : PI_ANG;
      end else begin
        a3_r <= xs3;
        b3_r <= ys3;
        g3_r <= '0;
      end
    end
  end

  // First CORDIC chain on (x, y): azimuth and the xy length.
  logic  c1_v [CS+1];
  side_t c1_s [CS+1];
  word_t c1_a [CS+1];
  word_t c1_b [CS+1];
  ang_t  c1_g [CS+1];

  assign c1_v[0] = v3_r;
  assign c1_s[0] = s3_r;
  assign c1_a[0] = a3_r;
  assign c1_b[0] = b3_r;
  assign c1_g[0] = g3_r;

  for (genvar k = 0; k < CS; k++) begin : g_chain1
    cts_cell #(.STG(k)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(c1_v[k]), .side_i(c1_s[k]), .a_i(c1_a[k]), .b_i(c1_b[k]), .ang_i(c1_g[k]),
      .vld_o(c1_v[k+1]), .side_o(c1_s[k+1]), .a_o(c1_a[k+1]), .b_o(c1_b[k+1]),
      .ang_o(c1_g[k+1])
    );
  end

  side_t gi1_s, go1_s;
  logic  go1_v;
  word_t go1_val;

  always_comb begin
    gi1_s     = c1_s[CS];
    gi1_s.phi = clamp_ang(c1_g[CS], -PI_ANG, PI_ANG);
  end

  cts_gain u_gain1 (
    .clk, .rst_n, .en,
    .vld_i(c1_v[CS]), .side_i(gi1_s), .val_i(c1_a[CS]),
    .vld_o(go1_v), .side_o(go1_s), .val_o(go1_val)
  );

  // Stage between chains: fold negative z onto the positive half.
  logic  v4_r;
  word_t a4_r, b4_r;
  ang_t  g4_r;
  side_t s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= go1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= go1_s;
      if (go1_s.zs[WORD_W-1]) begin
        a4_r <= -go1_s.zs;
        b4_r <= -go1_val;
        g4_r <= PI_ANG;
      end else begin
        a4_r <= go1_s.zs;
        b4_r <= go1_val;
        g4_r <= '0;
      end
    end
  end

  // Second CORDIC chain on (z, s): polar angle and radius.
  logic  c2_v [CS+1];
  side_t c2_s [CS+1];
  word_t c2_a [CS+1];
  word_t c2_b [CS+1];
  ang_t  c2_g [CS+1];

  assign c2_v[0] = v4_r;
  assign c2_s[0] = s4_r;
  assign c2_a[0] = a4_r;
  assign c2_b[0] = b4_r;
  assign c2_g[0] = g4_r;

  for (genvar k = 0; k < CS; k++) begin : g_chain2
    cts_cell #(.STG(k)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(c2_v[k]), .side_i(c2_s[k]), .a_i(c2_a[k]), .b_i(c2_b[k]), .ang_i(c2_g[k]),
      .vld_o(c2_v[k+1]), .side_o(c2_s[k+1]), .a_o(c2_a[k+1]), .b_o(c2_b[k+1]),
      .ang_o(c2_g[k+1])
    );
  end

  side_t gi2_s, go2_s;
  logic  go2_v;
  word_t go2_val;

  always_comb begin
    gi2_s       = c2_s[CS];
    gi2_s.theta = clamp_ang(c2_g[CS], '0, PI_ANG);
  end

  cts_gain u_gain2 (
    .clk, .rst_n, .en,
    .vld_i(c2_v[CS]), .side_i(gi2_s), .val_i(c2_a[CS]),
    .vld_o(go2_v), .side_o(go2_s), .val_o(go2_val)
  );

  // Output stage: denormalize, saturate, apply exact axis cases and round angles.
  word_t          rad_half, rad_sh, zab, rad_v;
  ang_t           theta_f, phi_f, theta_q, phi_q;
  logic [CB-1:0]  rad_r;
  logic [AB-1:0]  pol_r;
  logic [AB:0]    azi_r;

  always_comb begin
    rad_half = word_t'(1) << (go2_s.n - SHIFT_W'(1));
    rad_sh   = (go2_val + rad_half) >> go2_s.n;
    zab      = go2_s.z[WORD_W-1] ? -go2_s.z : go2_s.z;
    rad_v    = go2_s.axis ? zab : rad_sh;

    if (go2_s.axis) theta_f = go2_s.zneg ? PI_ANG : ang_t'(0);
    else if (go2_s.zzero) theta_f = HALF_PI_ANG;
    else theta_f = go2_s.theta;

    if (go2_s.axis) phi_f = '0;
    else if (go2_s.yzero) phi_f = go2_s.xneg ? PI_ANG : ang_t'(0);
    else if (go2_s.xzero) phi_f = go2_s.yneg ? -HALF_PI_ANG : HALF_PI_ANG;
    else phi_f = go2_s.phi;

    theta_q = round_ang(theta_f);
    phi_q   = round_ang(phi_f);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= go2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= (rad_v > RMAX) ? RMAX[CB-1:0] : rad_v[CB-1:0];
      pol_r <= theta_q[AB-1:0];
      azi_r <= phi_q[AB:0];
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.radius        = rad_r;
  assign out_ch.polar_angle   = pol_r;
  assign out_ch.azimuth_angle = azi_r;

  // An accepted request always enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted request did not enter the pipeline");

  // The polar angle never exceeds pi.
  a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_ch.polar_angle} <= LIM_ANG[AB:0]))
    else $error("polar angle out of range");

  // The azimuth stays within minus pi to pi.
  a_azimuth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.azimuth_angle) <= $signed(LIM_ANG[AB:0]) &&
                      $signed(out_ch.azimuth_angle) >= -$signed(LIM_ANG[AB:0])))
    else $error("azimuth out of range");

endmodule

`default_nettype wire

### tb/sv/tb_cartesian_to_spherical_point_unit.sv
// Testbench for the cartesian to spherical point unit, with its own spherical predictor.
`default_nettype none

module tb_cartesian_to_spherical_point_unit;
  import cts_pkg::*;

  localparam int CB = 24;
  localparam int AB = 18;
  localparam int STAGES = 20;
  localparam int LATENCY = 2 * STAGES + 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint PI_FIX = 64'sd2147483648;
  localparam longint unsigned GAIN_INV = 64'h9B74EDA8;
  localparam longint unsigned NORM_FLOOR = 64'd1 << NORM_MSB;
  localparam int ANG_LIM = 1 << (AB - 1);

  typedef struct {
    logic [CB-1:0]        radius;
    logic [AB-1:0]        polar;
    logic signed [AB:0]   azimuth;
  } spherical_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;
  spherical_t expected_sph_q[$];
  longint unsigned atan_rom[0:39];

  cts_in_if  #(.COORD_BITS(CB)) in_ch ();
  cts_out_if #(.COORD_BITS(CB), .ANGLE_BITS(AB)) out_ch ();

  cartesian_to_spherical_point_unit #(
    .COORD_BITS(CB), .ANGLE_BITS(AB), .CORDIC_STAGES(STAGES)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Arctangent of 2^-i, pi = 2^31.
  initial begin
    atan_rom = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
                 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
                 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
                 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
                 64'h00000001, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
  end

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Multiply by the inverse CORDIC gain as a 32x32 split product.
  function automatic longint scale_by_inv_gain(input longint v);
    longint unsigned u;
    u = v;
    return longint'((u >> 32) * GAIN_INV + (((u & 64'hFFFFFFFF) * GAIN_INV) >> 32));
  endfunction

  // Rotate (a, b) until b is zero, summing the applied angles.
  task automatic rotate_to_axis(inout longint a, inout longint b, inout longint ang);
    longint da;
    longint db;
    for (int i = 0; i < STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; ang += longint'(atan_rom[i]);
      end else begin
        a -= da; b += db; ang -= longint'(atan_rom[i]);
      end
    end
  endtask

  function automatic longint to_angle_units(input longint a);
    return clip((a + 64'sd8192) >>> (32 - AB), -ANG_LIM, ANG_LIM);
  endfunction

  task automatic predict_spherical(input logic signed [CB-1:0] xi, yi, zi,
                                   output spherical_t res);
    longint x, y, z, m, xs, ys, a, b, phi, theta, rad, a1, a2;
    int n;
    x = xi; y = yi; z = zi;
    phi = 0; theta = 0; rad = 0; a1 = 0; a2 = 0; n = 0;
    if (x == 0 && y == 0) begin
      // On the z axis the radius is exact and theta is 0 or pi.
      rad = abs64(z);
      theta = (z < 0) ? PI_FIX : 0;
    end else begin
      m = abs64(x);
      if (abs64(y) > m) m = abs64(y);
      if (abs64(z) > m) m = abs64(z);
      while (($unsigned(m) << n) < NORM_FLOOR) n++;
      xs = x <<< n;
      ys = y <<< n;
      if (xs < 0) begin
        xs = -xs; ys = -ys;
        a1 = (y >= 0) ? PI_FIX : -PI_FIX;
      end
      rotate_to_axis(xs, ys, a1);
      phi = clip(a1, -PI_FIX, PI_FIX);
      b = scale_by_inv_gain(xs);
      a = z <<< n;
      if (a < 0) begin
        a = -a; b = -b; a2 = PI_FIX;
      end
      rotate_to_axis(a, b, a2);
      theta = clip(a2, 0, PI_FIX);
      rad = (scale_by_inv_gain(a) + (64'sd1 <<< (n - 1))) >>> n;
      // Exact angles in the xy plane and on the x and y axes.
      if (z == 0) theta = PI_FIX / 2;
      if (y == 0) phi = (x < 0) ? PI_FIX : 0;
      else if (x == 0) phi = (y < 0) ? -(PI_FIX / 2) : PI_FIX / 2;
    end
    res.radius  = (rad > longint'((64'd1 << CB) - 1)) ? {CB{1'b1}} : rad[CB-1:0];
    res.polar   = AB'(to_angle_units(theta));
    res.azimuth = (AB+1)'(to_angle_units(phi));
  endtask

  // The block may differ from the predictor by one LSB.
  function automatic bit near(input longint e, input longint a);
    return abs64(e - a) <= 1;
  endfunction

  // Offer one request and wait until the block takes it.
  task automatic send_point(input logic signed [CB-1:0] x, y, z);
    spherical_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_coord <= x;
    in_ch.y_coord <= y;
    in_ch.z_coord <= z;
    do @(posedge clk); while (!in_ch.ready);
    predict_spherical(x, y, z, res);
    expected_sph_q.push_back(res);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_sph_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] pick_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return CB'($urandom_range(3) - 1);
      2: return {CB{1'b1}} ^ ($urandom_range(1) ? 24'h7FFFFF : 24'h0);
      3: return CB'(int'($urandom_range(255)) - 128);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [CB-1:0] mx, mn;
    mx = 24'sh7FFFFF;
    mn = 24'sh800000;
    send_point(0, 0, 0);
    send_point(0, 0, 5);
    send_point(0, 0, -5);
    send_point(0, 0, mx);
    send_point(0, 0, mn);
    send_point(7, 3, 0);
    send_point(mn, mn, 0);
    send_point(100, 0, 9);
    send_point(-100, 0, 9);
    send_point(0, 100, -9);
    send_point(0, -100, -9);
    send_point(mx, mx, mx);
    send_point(mn, mn, mn);
    send_point(mn, mx, mn);
    send_point(mx, mn, mx);
    send_point(1, 1, 1);
    send_point(-1, -1, -1);
    send_point(-1, 1, 0);
    send_point(mn, 0, 0);
    send_point(0, mn, mx);
    send_point(-3, -1, 2);
    drain_results();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_point(pick_coord(), pick_coord(), pick_coord());
    drain_results();
  endtask

  // Stall the output long enough for the pipeline to fill and stop the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 3 * LATENCY;
    repeat (150) send_point(CB'($urandom), CB'($urandom), CB'($urandom));
    drain_results();
  endtask

  // Result checker and output ready generation.
  always @(posedge clk) begin
    spherical_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_sph_q.size() == 0) begin
        $error("unexpected result radius=%0d", out_ch.radius);
        error_count++;
      end else begin
        e = expected_sph_q.pop_front();
        if (!near(e.radius, out_ch.radius)) begin
          $error("radius: expected %0d, got %0d", e.radius, out_ch.radius);
          error_count++;
        end
        if (!near(e.polar, out_ch.polar_angle)) begin
          $error("polar_angle: expected %0d, got %0d", e.polar, out_ch.polar_angle);
          error_count++;
        end
        if (!near(e.azimuth, out_ch.azimuth_angle)) begin
          $error("azimuth_angle: expected %0d, got %0d", e.azimuth, out_ch.azimuth_angle);
          error_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_coord = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 28, 65);
    test_random(500, 65, 28);
    test_random(380, 0, 0);
    test_backpressure();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
